/* rtl/ciu_pkg.sv */
// package for the execute unit: opcodes, controller states, command and status types
`timescale 1ns / 1ps
`default_nettype none
package ciu_pkg;
  localparam int NUM_REGS_DEF = 32;
  localparam int MEM_WORDS_DEF = 4096;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int REG_AW = 5;

  localparam logic [5:0] OP_ADD = 6'h01, OP_SUB = 6'h02, OP_AND = 6'h03, OP_OR = 6'h04,
    OP_XOR = 6'h05, OP_LSL = 6'h06, OP_LSR = 6'h07, OP_LDR = 6'h08, OP_STR = 6'h09,
    OP_JMP = 6'h0A, OP_JAL = 6'h0B, OP_BEQ = 6'h0C, OP_BNE = 6'h0D, OP_MOV = 6'h0E,
    OP_CMP = 6'h0F, OP_PUSH = 6'h10, OP_POP = 6'h11, OP_CALL = 6'h12, OP_RET = 6'h13,
    OP_IRET = 6'h14, OP_NOP = 6'h15, OP_HLT = 6'h16, OP_MUL = 6'h17, OP_DIV = 6'h18,
    OP_MOD = 6'h19, OP_NOT = 6'h1A, OP_NEG = 6'h1B, OP_INC = 6'h1C, OP_DEC = 6'h1D,
    OP_ASL = 6'h1E, OP_ASR = 6'h1F, OP_SWI = 6'h20, OP_SEXT = 6'h21, OP_ZEXT = 6'h22,
    OP_MFS = 6'h23, OP_MTS = 6'h24, OP_OUT = 6'h25, OP_IN = 6'h26;

  localparam logic [7:0] TRAP_INVALID = 8'h01;
  localparam logic [7:0] FLAG_ZERO = 8'h02;
  localparam logic [7:0] FLAG_SIGN = 8'h04;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MEM, ST_WB, ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic read;
    logic exec;
    logic div_start;
    logic mem_cap;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic is_mem_read;
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

/* rtl/ciu_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ciu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/ciu_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ciu_divider import ciu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] quotient,
  output logic      [DATA_WIDTH-1:0] remainder
);
  localparam int CW = $clog2(DATA_WIDTH + 1);
  logic [CW-1:0] count;
  logic busy;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH:0] trial;
  always_comb trial = {remainder, quotient[DATA_WIDTH-1]} - {1'b0, dvs};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(DATA_WIDTH);
        quotient <= dividend;
        remainder <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (trial[DATA_WIDTH]) begin
          remainder <= {remainder[DATA_WIDTH-2:0], quotient[DATA_WIDTH-1]};
          quotient <= {quotient[DATA_WIDTH-2:0], 1'b0};
        end else begin
          remainder <= trial[DATA_WIDTH-1:0];
          quotient <= {quotient[DATA_WIDTH-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/ciu_control.sv */
// controller state machine: sequences read, execute, divide, memory, writeback and output
`timescale 1ns / 1ps
`default_nettype none
module ciu_control import ciu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t stat,
  output cmd_t         cmd
);
  state_t state, state_next;
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_next = stat.is_mem_read ? ST_MEM : ST_WB;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.exec = 1'b1;
          state_next = ST_WB;
        end
      end
      ST_MEM: begin
        cmd.mem_cap = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/ciu_datapath.sv */
// datapath: register file, alu, divider, data memory, pc, sp and flags
`timescale 1ns / 1ps
`default_nettype none
module ciu_datapath import ciu_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF,
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    stat,
  input  wire logic [63:0]           instruction_word,
  input  wire logic [DATA_WIDTH-1:0] io_in_data,
  output logic                       trap_valid,
  output logic      [7:0]            trap_vector,
  output logic                       iret_request,
  output logic                       halted,
  output logic                       io_write_valid,
  output logic                       io_read_valid,
  output logic      [4:0]            io_port,
  output logic      [DATA_WIDTH-1:0] io_write_data,
  output logic      [DATA_WIDTH-1:0] program_counter,
  output logic      [7:0]            flag_bits
);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam logic [DATA_WIDTH-1:0] SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [63:0] iw;
  logic [DATA_WIDTH-1:0] io_in;
  logic [DATA_WIDTH-1:0] regs [NUM_REGS];
  logic [DATA_WIDTH-1:0] pc, sp;
  logic [7:0] flags;
  logic [DATA_WIDTH-1:0] a, b, d;
  logic [DATA_WIDTH-1:0] res;
  logic res_we, res_flags, res_is_cmp;
  logic [REG_AW-1:0] res_dst;

  logic [5:0] op, sh;
  logic [REG_AW-1:0] rd, rs1, rs2;
  logic [DATA_WIDTH-1:0] imm, jaddr;
  assign op = iw[63:58];
  assign rd = iw[57:53];
  assign rs1 = iw[52:48];
  assign rs2 = iw[47:43];
  assign sh = iw[42:37];
  assign imm = iw[47:16];
  assign jaddr = iw[57:26];

  logic div_done;
  logic [DATA_WIDTH-1:0] quo, rem;
  ciu_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk, .rst, .start(cmd.div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  logic mem_we;
  logic [MAW-1:0] mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  ciu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_WORDS)) u_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  assign stat.is_div = (op == OP_DIV) || (op == OP_MOD);
  assign stat.is_mem_read = (op == OP_LDR) || (op == OP_POP) || (op == OP_RET);
  assign stat.div_done = div_done;

  logic [DATA_WIDTH-1:0] spm4, ea;
  assign spm4 = sp - DATA_WIDTH'(4);
  assign ea = a + imm;

  always_comb begin
    mem_we = 1'b0;
    mem_addr = sp[MAW+1:2];
    mem_wdata = d;
    if (cmd.exec) begin
      unique case (op)
        OP_LDR: mem_addr = ea[MAW+1:2];
        OP_STR: begin mem_we = 1'b1; mem_addr = ea[MAW+1:2]; end
        OP_PUSH: begin mem_we = 1'b1; mem_addr = spm4[MAW+1:2]; end
        OP_CALL: begin mem_we = 1'b1; mem_addr = spm4[MAW+1:2]; mem_wdata = pc; end
        default: mem_addr = sp[MAW+1:2];
      endcase
    end
  end

  logic [DATA_WIDTH-1:0] sar, alu_r;
  logic alu_op;
  assign sar = sh >= 6'd32 ? {DATA_WIDTH{a[DATA_WIDTH-1]}} :
               DATA_WIDTH'($signed(a) >>> sh[4:0]);
  always_comb begin
    alu_op = 1'b1;
    alu_r = '0;
    unique case (op)
      OP_ADD: alu_r = a + b;
      OP_SUB: alu_r = a - b;
      OP_AND: alu_r = a & b;
      OP_OR: alu_r = a | b;
      OP_XOR: alu_r = a ^ b;
      OP_LSL, OP_ASL: alu_r = sh >= 6'd32 ? '0 : a << sh[4:0];
      OP_LSR: alu_r = sh >= 6'd32 ? '0 : a >> sh[4:0];
      OP_MUL: alu_r = a * b;
      OP_DIV: alu_r = (b == '0) ? '1 : quo;
      OP_MOD: alu_r = (b == '0) ? a : rem;
      OP_NOT: alu_r = ~a;
      OP_NEG: alu_r = '0 - a;
      OP_INC: alu_r = d + 1'b1;
      OP_DEC: alu_r = d - 1'b1;
      OP_ASR: alu_r = sar;
      default: alu_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      iw <= instruction_word;
      io_in <= io_in_data;
    end
    if (cmd.read) begin
      a <= regs[rs1];
      b <= regs[rs2];
      d <= regs[rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
      pc <= '0;
      sp <= '0;
      flags <= '0;
      res_we <= 1'b0;
      res_flags <= 1'b0;
      res_is_cmp <= 1'b0;
      trap_valid <= 1'b0;
      trap_vector <= '0;
      iret_request <= 1'b0;
      halted <= 1'b0;
      io_write_valid <= 1'b0;
      io_read_valid <= 1'b0;
      io_port <= '0;
      io_write_data <= '0;
    end else begin
      if (cmd.exec) begin
        res_we <= 1'b0;
        res_flags <= alu_op;
        res_is_cmp <= 1'b0;
        res_dst <= rd;
        res <= alu_r;
        trap_valid <= 1'b0;
        trap_vector <= '0;
        iret_request <= 1'b0;
        halted <= 1'b0;
        io_write_valid <= 1'b0;
        io_read_valid <= 1'b0;
        io_port <= '0;
        io_write_data <= '0;
        if (alu_op) res_we <= 1'b1;
        else begin
          unique case (op)
            OP_LDR, OP_POP: res_we <= 1'b1;
            OP_STR, OP_PUSH, OP_IRET, OP_NOP, OP_HLT, OP_RET: ;
            OP_BEQ: if (a == d) pc <= pc + imm;
            OP_BNE: if (a != d) pc <= pc + imm;
            OP_MOV, OP_SEXT, OP_ZEXT, OP_MFS: begin res_we <= 1'b1; res <= a; end
            OP_CMP: begin res_is_cmp <= 1'b1; res <= a - d; end
            OP_SWI: begin trap_valid <= 1'b1; trap_vector <= imm[7:0]; end
            OP_MTS: begin res_we <= 1'b1; res_dst <= rs1; res <= d; end
            OP_OUT: begin
              io_write_valid <= 1'b1; io_port <= rd; io_write_data <= a;
            end
            OP_IN: begin
              io_read_valid <= 1'b1; io_port <= rd;
              res_we <= 1'b1; res_dst <= rs1; res <= io_in;
            end
            OP_JMP: pc <= jaddr;
            OP_JAL: begin
              res_we <= 1'b1; res_dst <= REG_AW'(NUM_REGS - 1); res <= pc; pc <= jaddr;
            end
            OP_CALL: pc <= jaddr;
            default: begin trap_valid <= 1'b1; trap_vector <= TRAP_INVALID; end
          endcase
          if (op == OP_PUSH || op == OP_CALL) sp <= spm4;
          if (op == OP_IRET) iret_request <= 1'b1;
          if (op == OP_HLT) halted <= 1'b1;
        end
      end
      if (cmd.mem_cap) begin
        if (op == OP_RET) pc <= mem_rdata;
        else res <= mem_rdata;
        sp <= sp + DATA_WIDTH'(4);
        if (op == OP_LDR) sp <= sp;
      end
      if (cmd.wb) begin
        if (res_we) regs[res_dst] <= res;
        if (res_flags || res_is_cmp) begin
          flags <= flags | ((res == '0) ? FLAG_ZERO : 8'h00)
                         | (((res & SIGN) != '0) ? FLAG_SIGN : 8'h00);
        end
      end
    end
  end

  assign program_counter = pc;
  assign flag_bits = flags;
endmodule
`default_nettype wire

/* rtl/custom_isa_execute_unit.sv */
// top level of the execute unit
//   channel  | handshake             | payload
//   in       | in_valid / in_stall   | instruction_word, io_in_data
//   out      | out_valid / out_stall | trap, iret, halt, io, pc, flags
// a transaction steps through idle, read, execute, writeback and out between accepts,
// and the result shows in the out state
// loads, pop and ret add a memory state for the registered data memory read
// div and mod add a divide state that waits for the 32-step bit-serial divider
// a new transaction is taken once the result has left; synchronous reset clears
// registers, pc, sp and flags; data memory content is undefined until written
`timescale 1ns / 1ps
`default_nettype none
module custom_isa_execute_unit import ciu_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF,
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [63:0]           instruction_word,
  input  wire logic [DATA_WIDTH-1:0] io_in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       trap_valid,
  output logic      [7:0]            trap_vector,
  output logic                       iret_request,
  output logic                       halted,
  output logic                       io_write_valid,
  output logic                       io_read_valid,
  output logic      [4:0]            io_port,
  output logic      [DATA_WIDTH-1:0] io_write_data,
  output logic      [DATA_WIDTH-1:0] program_counter,
  output logic      [7:0]            flag_bits
);
  cmd_t cmd;
  status_t stat;
  ciu_control u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );
  ciu_datapath #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat, .instruction_word, .io_in_data, .trap_valid, .trap_vector,
    .iret_request, .halted, .io_write_valid, .io_read_valid, .io_port, .io_write_data,
    .program_counter, .flag_bits
  );
endmodule
`default_nettype wire

/* rtl/ciu_checker.sv */
// port-level checker for the execute unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ciu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] flag_bits,
  input wire logic       trap_valid,
  input wire logic [7:0] trap_vector
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    ((($past(flag_bits) & ~flag_bits) == 8'h00) || $past(rst)))
    else $error("flag cleared");
  a_no_vec_without_trap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trap_valid |-> trap_vector == 8'h00) else $error("stray vector");
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid) else $error("accept sequencing");
endmodule
bind custom_isa_execute_unit ciu_checker u_ciu_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .flag_bits,
  .trap_valid, .trap_vector
);
`default_nettype wire
